// File: rtl/det_pkg.sv
package det_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int IDX_W       = $clog2(EVENT_SLOTS);
  localparam int DCNT_W      = $clog2(EVENT_SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W = 32;
  localparam int MULT_W = 8;
  localparam int TAG_W  = 8;
  localparam int LFSR_W = 16;
  localparam int SPAN_W = MULT_W + 1;
  localparam int PROD_W = TIME_W + MULT_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'h0001;

  // paddr[2] picks the register word
  localparam logic REG_SEED = 1'b0;

  typedef enum logic {
    ACT_INSERT,
    ACT_TICK
  } action_e;

  typedef enum logic [1:0] {
    ST_INSERTED,
    ST_FULL,
    ST_FIRED,
    ST_NONE_DUE
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_DUE,
    S_FIND,
    S_EMIT_END,
    S_EMIT_FIRE,
    S_RESCH,
    S_DIV,
    S_MUL,
    S_ADD
  } state_e;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } rem_req_t;

endpackage

// File: rtl/det_rem.sv
// Restoring remainder, one dividend bit per cycle.
module det_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  det_pkg::rem_req_t         req_i,
  output logic                      done_o,
  output logic [det_pkg::SPAN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(det_pkg::LFSR_W);

  logic                       busy_q, done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [det_pkg::LFSR_W-1:0] dvd_q;
  logic [det_pkg::SPAN_W-1:0] rem_q, div_q;
  logic [det_pkg::SPAN_W:0]   trial, diff;
  logic                       ge;

  assign trial = {rem_q, dvd_q[det_pkg::LFSR_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(det_pkg::LFSR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[det_pkg::LFSR_W-2:0], 1'b0};
      rem_q <= ge ? diff[det_pkg::SPAN_W-1:0] : trial[det_pkg::SPAN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/deadline_event_timer_table.sv
// Channel  | handshake                     | payload
// ---------+-------------------------------+---------------------------------------------
// request  | in_valid_i / in_ready_o       | action, now_time, trigger_at, repeat_interval,
//          |                               | mult_low, mult_high, event_kind, event_tag
// result   | out_valid_o / out_ready_i     | status, fired_kind, fired_tag, last
// config   | APB psel/penable/pwrite       | random_seed at byte address 0
//
// Sequence: an insert walks the slots for the lowest free one. A tick first walks
//   all slots for the due snapshot, then per fired event walks them for the minimum
//   deadline, emits the event and reschedules it, where a random draw waits on the
//   serial remainder unit.
// Each walk goes slot by slot through the single table read port.
// in_ready_o is high only in idle; a pending result register lets one finished
//   result wait while the next request is taken. A stalled result stalls the walk.
// Reset clears the valid bits, the LFSR (to the seed reset) and all control state.
module deadline_event_timer_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [det_pkg::TIME_W-1:0]   now_time_i,
  input  logic [det_pkg::TIME_W-1:0]   trigger_at_i,
  input  logic [det_pkg::TIME_W-1:0]   repeat_interval_i,
  input  logic [det_pkg::MULT_W-1:0]   mult_low_i,
  input  logic [det_pkg::MULT_W-1:0]   mult_high_i,
  input  logic                         event_kind_i,
  input  logic [det_pkg::TAG_W-1:0]    event_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         fired_kind_o,
  output logic [det_pkg::TAG_W-1:0]    fired_tag_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int N  = det_pkg::EVENT_SLOTS;
  localparam int IW = det_pkg::IDX_W;
  localparam int DW = det_pkg::DCNT_W;
  localparam int FW = det_pkg::FCNT_W;
  localparam int TW = det_pkg::TIME_W;
  localparam int MW = det_pkg::MULT_W;
  localparam int LW = det_pkg::LFSR_W;
  localparam int SW = det_pkg::SPAN_W;

  // slot table; payload has no reset, gated by valid_q
  logic [TW-1:0] dl_q   [N];
  logic [TW-1:0] ivl_q  [N];
  logic [MW-1:0] lo_q   [N];
  logic [MW-1:0] hi_q   [N];
  logic          kind_q [N];
  logic [7:0]    tag_q  [N];
  logic [N-1:0]  valid_q, due_q;

  det_pkg::state_e  state_q, state_d;
  det_pkg::status_e res_status_q, res_status_d, out_status_q;

  logic [IW-1:0] idx_q, pick_q, rd_addr;
  logic [DW-1:0] due_cnt_q;
  logic [FW-1:0] fire_cnt_q;
  logic          found_q;
  logic [TW-1:0] best_dl_q;

  // latched request
  logic [TW-1:0] now_q, trig_q, ivl_in_q;
  logic [MW-1:0] lo_in_q, hi_in_q;
  logic          kind_in_q;
  logic [7:0]    tag_in_q;

  logic [LW-1:0]             seed_q, lfsr_q, lfsr_nx;
  logic [MW-1:0]             mult_q;
  logic [SW-1:0]             span_q, span;
  logic [det_pkg::PROD_W-1:0] prod_q;
  logic [det_pkg::SUM_W-1:0]  sum;
  logic [TW-1:0]             new_dl;

  logic          out_valid_q, out_kind_q, out_last_q;
  logic [7:0]    out_tag_q;

  // strobes
  logic accept, scan_last, out_free, due_now, cand, cfg_wr;
  logic tick_init, ins_init, scan_adv, ins_wr, due_upd, find_upd, emit_end, emit_fire;
  logic mult_direct, draw_go, mul_ld, dl_wr, fire_last;

  det_pkg::rem_req_t       rem_req;
  logic                    rem_done;
  logic [SW-1:0]           rem_val;

  logic [TW-1:0] rd_dl, rd_ivl;
  logic [MW-1:0] rd_lo, rd_hi;
  logic          rd_kind;
  logic [7:0]    rd_tag;

  assign rd_addr = (state_q == det_pkg::S_FREE || state_q == det_pkg::S_DUE ||
                    state_q == det_pkg::S_FIND) ? idx_q : pick_q;
  assign rd_dl   = dl_q[rd_addr];
  assign rd_ivl  = ivl_q[rd_addr];
  assign rd_lo   = lo_q[rd_addr];
  assign rd_hi   = hi_q[rd_addr];
  assign rd_kind = kind_q[rd_addr];
  assign rd_tag  = tag_q[rd_addr];

  assign in_ready_o = (state_q == det_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_last  = (idx_q == IW'(N - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign due_now    = valid_q[idx_q] && (rd_dl <= now_q);
  // slot 0 opens a fresh search, so the previous best is ignored there
  assign cand       = due_q[idx_q] && (idx_q == '0 || !found_q || rd_dl < best_dl_q);
  assign fire_last  = (due_cnt_q == DW'(1)) || (fire_cnt_q == FW'(det_pkg::MAX_RESULTS - 1));

  // Galois LFSR step, span of the random range
  assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ det_pkg::LFSR_MASK) : (lfsr_q >> 1);
  assign span    = {1'b0, rd_hi} - {1'b0, rd_lo} + SW'(1);

  assign sum    = {1'b0, {(det_pkg::PROD_W - TW){1'b0}}, rd_dl} + {1'b0, prod_q};
  assign new_dl = (sum[det_pkg::SUM_W-1:TW] != '0) ? '1 : sum[TW-1:0];

  // next state
  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    unique case (state_q)
      det_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (det_pkg::action_e'(action_i) == det_pkg::ACT_INSERT) ?
                    det_pkg::S_FREE : det_pkg::S_DUE;
        end
      end
      det_pkg::S_FREE: begin
        if (!valid_q[idx_q]) begin
          state_d      = det_pkg::S_EMIT_END;
          res_status_d = det_pkg::ST_INSERTED;
        end else if (scan_last) begin
          state_d      = det_pkg::S_EMIT_END;
          res_status_d = det_pkg::ST_FULL;
        end
      end
      det_pkg::S_DUE: begin
        if (scan_last) begin
          if (due_cnt_q == '0 && !due_now) begin
            state_d      = det_pkg::S_EMIT_END;
            res_status_d = det_pkg::ST_NONE_DUE;
          end else begin
            state_d = det_pkg::S_FIND;
          end
        end
      end
      det_pkg::S_FIND:      if (scan_last) state_d = det_pkg::S_EMIT_FIRE;
      det_pkg::S_EMIT_END:  if (out_free) state_d = det_pkg::S_IDLE;
      det_pkg::S_EMIT_FIRE: if (out_free) state_d = det_pkg::S_RESCH;
      det_pkg::S_RESCH: begin
        if (rd_ivl == '0) begin
          state_d = (due_cnt_q == '0 || fire_cnt_q == FW'(det_pkg::MAX_RESULTS)) ?
                    det_pkg::S_IDLE : det_pkg::S_FIND;
        end else if (rd_lo == '0 || rd_hi < rd_lo) begin
          state_d = det_pkg::S_MUL;
        end else begin
          state_d = det_pkg::S_DIV;
        end
      end
      det_pkg::S_DIV: if (rem_done) state_d = det_pkg::S_MUL;
      det_pkg::S_MUL: state_d = det_pkg::S_ADD;
      det_pkg::S_ADD: begin
        state_d = (due_cnt_q == '0 || fire_cnt_q == FW'(det_pkg::MAX_RESULTS)) ?
                  det_pkg::S_IDLE : det_pkg::S_FIND;
      end
      default: state_d = det_pkg::S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    tick_init   = 1'b0;
    ins_init    = 1'b0;
    scan_adv    = 1'b0;
    ins_wr      = 1'b0;
    due_upd     = 1'b0;
    find_upd    = 1'b0;
    emit_end    = 1'b0;
    emit_fire   = 1'b0;
    mult_direct = 1'b0;
    draw_go     = 1'b0;
    mul_ld      = 1'b0;
    dl_wr       = 1'b0;
    unique case (state_q)
      det_pkg::S_IDLE: begin
        tick_init = accept && (det_pkg::action_e'(action_i) == det_pkg::ACT_TICK);
        ins_init  = accept && (det_pkg::action_e'(action_i) == det_pkg::ACT_INSERT);
      end
      det_pkg::S_FREE: begin
        ins_wr   = !valid_q[idx_q];
        scan_adv = 1'b1;
      end
      det_pkg::S_DUE: begin
        due_upd  = 1'b1;
        scan_adv = 1'b1;
      end
      det_pkg::S_FIND: begin
        find_upd = cand;
        scan_adv = 1'b1;
      end
      det_pkg::S_EMIT_END:  emit_end  = out_free;
      det_pkg::S_EMIT_FIRE: emit_fire = out_free;
      det_pkg::S_RESCH: begin
        mult_direct = (rd_ivl != '0) && (rd_lo == '0 || rd_hi < rd_lo);
        draw_go     = (rd_ivl != '0) && (rd_lo != '0) && !(rd_hi < rd_lo);
      end
      det_pkg::S_DIV: mul_ld = 1'b0;
      det_pkg::S_MUL: mul_ld = 1'b1;
      det_pkg::S_ADD: dl_wr  = 1'b1;
      default: ;
    endcase
  end

  assign rem_req.start    = draw_go;
  assign rem_req.dividend = lfsr_nx;
  assign rem_req.divisor  = span;

  det_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= det_pkg::S_IDLE;
      res_status_q <= det_pkg::ST_INSERTED;
      valid_q      <= '0;
      due_q        <= '0;
      due_cnt_q    <= '0;
      fire_cnt_q   <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      seed_q       <= det_pkg::SEED_RESET;
      lfsr_q       <= det_pkg::SEED_RESET;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;

      if (tick_init || ins_init) idx_q <= '0;
      else if (scan_adv) idx_q <= scan_last ? '0 : idx_q + IW'(1);

      if (tick_init) begin
        due_q      <= '0;
        due_cnt_q  <= '0;
        fire_cnt_q <= '0;
      end
      if (due_upd && due_now) begin
        due_q[idx_q] <= 1'b1;
        due_cnt_q    <= due_cnt_q + DW'(1);
      end

      if (state_q == det_pkg::S_FIND && idx_q == '0) found_q <= find_upd;
      else if (find_upd) found_q <= 1'b1;

      if (ins_wr) valid_q[idx_q] <= 1'b1;

      if (emit_fire) begin
        due_q[pick_q] <= 1'b0;
        due_cnt_q     <= due_cnt_q - DW'(1);
        fire_cnt_q    <= fire_cnt_q + FW'(1);
      end
      if (state_q == det_pkg::S_RESCH && rd_ivl == '0) valid_q[pick_q] <= 1'b0;

      if (emit_end || emit_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (cfg_wr && paddr[2] == det_pkg::REG_SEED) begin
        seed_q <= pwdata[LW-1:0];
        lfsr_q <= (pwdata[LW-1:0] == '0) ? det_pkg::SEED_RESET : pwdata[LW-1:0];
      end else if (draw_go) begin
        lfsr_q <= lfsr_nx;
      end
    end
  end

  // datapath and table payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q     <= now_time_i;
      trig_q    <= trigger_at_i;
      ivl_in_q  <= repeat_interval_i;
      lo_in_q   <= mult_low_i;
      hi_in_q   <= mult_high_i;
      kind_in_q <= event_kind_i;
      tag_in_q  <= event_tag_i;
    end
    if (ins_wr) begin
      dl_q[idx_q]   <= trig_q;
      ivl_q[idx_q]  <= ivl_in_q;
      lo_q[idx_q]   <= lo_in_q;
      hi_q[idx_q]   <= hi_in_q;
      kind_q[idx_q] <= kind_in_q;
      tag_q[idx_q]  <= tag_in_q;
    end
    if (dl_wr) dl_q[pick_q] <= new_dl;

    if (find_upd) begin
      pick_q    <= idx_q;
      best_dl_q <= rd_dl;
    end

    if (mult_direct) mult_q <= (rd_lo == '0) ? MW'(1) : rd_lo;
    if (draw_go) span_q <= span;
    if (state_q == det_pkg::S_DIV && rem_done) mult_q <= rd_lo + rem_val[MW-1:0];
    if (mul_ld) begin
      prod_q <= {{(det_pkg::PROD_W - MW){1'b0}}, mult_q} *
                {{(det_pkg::PROD_W - TW){1'b0}}, rd_ivl};
    end

    if (emit_end) begin
      out_status_q <= res_status_q;
      out_kind_q   <= 1'b0;
      out_tag_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (emit_fire) begin
      out_status_q <= det_pkg::ST_FIRED;
      out_kind_q   <= rd_kind;
      out_tag_q    <= rd_tag;
      out_last_q   <= fire_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign fired_kind_o = out_kind_q;
  assign fired_tag_o  = out_tag_q;
  assign last_o       = out_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == det_pkg::REG_SEED) ? {16'h0000, seed_q} : 32'h0000_0000;

  // due count tracks the due bits
  a_due_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(due_cnt_q) == $countones(due_q))
    else $error("due count out of step with due bits");

  // a fired event is a live, due slot
  a_fire_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == det_pkg::S_EMIT_FIRE) |-> (due_q[pick_q] && valid_q[pick_q]))
    else $error("firing a slot that is not due");

  // remainder stays in range
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == det_pkg::S_DIV && rem_done) |-> (rem_val < span_q))
    else $error("remainder out of range");

endmodule
